// ===== src/tscr_pkg.sv =====
// shared types, codes and constant tables of the thumb-shift chord resolver
// no dependencies
package tscr_pkg;

    typedef struct packed {
        logic        hit;
        logic [23:0] plain;
        logic [23:0] lpl;
        logic [23:0] rpl;
    } kana_row_t;

    typedef struct packed {
        logic       pressed;
        logic       shifted;
        logic [7:0] code;
    } key_word_t;

    localparam logic [1:0] CFG_WINDOW     = 2'd0;
    localparam logic [1:0] CFG_CONTINUOUS = 2'd1;
    localparam logic [1:0] CFG_LEFT_KEY   = 2'd2;
    localparam logic [1:0] CFG_RIGHT_KEY  = 2'd3;

    localparam logic [1:0] POST_NONE    = 2'd0;
    localparam logic [1:0] POST_PRESS   = 2'd1;
    localparam logic [1:0] POST_RELEASE = 2'd2;
    localparam logic [1:0] POST_TAP     = 2'd3;

    localparam logic [9:0] WINDOW_MIN   = 10'd1;
    localparam logic [9:0] WINDOW_MAX   = 10'd1000;
    localparam logic [9:0] WINDOW_RESET = 10'd130;
    localparam logic [7:0] LEFT_RESET   = 8'd44;
    localparam logic [7:0] RIGHT_RESET  = 8'd138;
    localparam logic [4:0] MAX_RESULTS  = 5'd16;

    localparam logic [7:0] CODE_A     = 8'd4;
    localparam logic [7:0] CODE_MINUS = 8'd45;
    localparam logic [7:0] CODE_COMMA = 8'd54;
    localparam logic [7:0] CODE_DOT   = 8'd55;
    localparam logic [7:0] CODE_SLASH = 8'd56;

    // romaji rows: strings right-justified, unused leading bytes zero
    function automatic kana_row_t kana_row(input logic [7:0] code);
        kana_row_t r;
        r = '{1'b1, 24'd0, 24'd0, 24'd0};
        case (code)
            8'd20: r = '{1'b1, 24'("."),  24'("la"),  24'd0};
            8'd26: r = '{1'b1, 24'("ka"), 24'("e"),   24'("ga")};
            8'd8:  r = '{1'b1, 24'("ta"), 24'("ri"),  24'("da")};
            8'd21: r = '{1'b1, 24'("ko"), 24'("lya"), 24'("go")};
            8'd23: r = '{1'b1, 24'("sa"), 24'("re"),  24'("za")};
            8'd28: r = '{1'b1, 24'("ra"), 24'("pa"),  24'("yo")};
            8'd24: r = '{1'b1, 24'("ti"), 24'("di"),  24'("ni")};
            8'd12: r = '{1'b1, 24'("ku"), 24'("gu"),  24'("ru")};
            8'd18: r = '{1'b1, 24'("tu"), 24'("du"),  24'("ma")};
            8'd19: r = '{1'b1, 24'(","),  24'("pi"),  24'("le")};
            8'd4:  r = '{1'b1, 24'("u"),  24'("wo"),  24'("vu")};
            8'd22: r = '{1'b1, 24'("si"), 24'("a"),   24'("zi")};
            8'd7:  r = '{1'b1, 24'("te"), 24'("na"),  24'("de")};
            8'd9:  r = '{1'b1, 24'("ke"), 24'("lyu"), 24'("ge")};
            8'd10: r = '{1'b1, 24'("se"), 24'("mo"),  24'("ze")};
            8'd11: r = '{1'b1, 24'("ha"), 24'("ba"),  24'("mi")};
            8'd13: r = '{1'b1, 24'("to"), 24'("do"),  24'("o")};
            8'd14: r = '{1'b1, 24'("ki"), 24'("gi"),  24'("no")};
            8'd15: r = '{1'b1, 24'("i"),  24'("po"),  24'("lyo")};
            8'd51: r = '{1'b1, 24'("nn"), 24'd0,      24'("ltu")};
            8'd29: r = '{1'b1, 24'("."),  24'("lu"),  24'd0};
            8'd27: r = '{1'b1, 24'("hi"), 24'("-"),   24'("bi")};
            8'd6:  r = '{1'b1, 24'("su"), 24'("ro"),  24'("zu")};
            8'd25: r = '{1'b1, 24'("hu"), 24'("ya"),  24'("bu")};
            8'd5:  r = '{1'b1, 24'("he"), 24'("li"),  24'("be")};
            8'd17: r = '{1'b1, 24'("me"), 24'("pu"),  24'("nu")};
            8'd16: r = '{1'b1, 24'("so"), 24'("zo"),  24'("yu")};
            8'd54: r = '{1'b1, 24'("ne"), 24'("pe"),  24'("mu")};
            8'd55: r = '{1'b1, 24'("ho"), 24'("bo"),  24'("wa")};
            8'd56: r = '{1'b1, 24'("/"),  24'("?"),   24'("lo")};
            8'd47: r = '{1'b1, 24'(","),  24'd0,      24'd0};
            default: r = '{1'b0, 24'd0, 24'd0, 24'd0};
        endcase
        return r;
    endfunction

    // romaji character to {shifted, usage code}
    function automatic logic [8:0] char_key(input logic [7:0] c);
        logic [8:0] k;
        k = 9'd0;
        case (c)
            "-": k = {1'b0, CODE_MINUS};
            ",": k = {1'b0, CODE_COMMA};
            ".": k = {1'b0, CODE_DOT};
            "/": k = {1'b0, CODE_SLASH};
            "?": k = {1'b1, CODE_SLASH};
            default: k = {1'b0, CODE_A + (c - 8'h61)};
        endcase
        return k;
    endfunction

    function automatic logic [3:0] sat4(input logic [4:0] v);
        return (v > 5'd15) ? 4'd15 : v[3:0];
    endfunction

endpackage

// ===== src/thumb_shift_chord_resolver.sv =====
// thumb-shift chord resolver top level: sequencer, key stores, output register
// depends on tscr_pkg
//
// One event is taken when s_tready is high; s_tready then stays low until every
// output word of that event has been handed to the output register. Each step of
// the sequencer does one compare, one character slot or one emitted word: a
// release first scans the pass-through entries, then each pending key is looked
// up and its three character slots are walked (a slot with a character sends a
// press and a release word), then a pass-through press or release or a solo tap
// is sent; any step that emits may wait on m_tready. Configuration writes are
// always accepted (cfg_ready is tied high).
module thumb_shift_chord_resolver #(
    parameter int PENDING_DEPTH     = 8,
    parameter int PASSTHROUGH_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key_code[7:0], event_time_ms[39:8], mods_held[40]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_code[7:0], out_shifted[8], out_pressed[9]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int PCW  = $clog2(PENDING_DEPTH + 1);
    localparam int PIW  = $clog2(PENDING_DEPTH);
    localparam int TCW  = $clog2(PASSTHROUGH_DEPTH + 1);
    localparam int TIW  = (PASSTHROUGH_DEPTH > 1) ? $clog2(PASSTHROUGH_DEPTH) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_SHIFT  = 4'd2;
    localparam logic [3:0] ST_DECODE = 4'd3;
    localparam logic [3:0] ST_LOOK   = 4'd4;
    localparam logic [3:0] ST_CHAR   = 4'd5;
    localparam logic [3:0] ST_POST   = 4'd6;
    localparam logic [3:0] ST_FLUSH  = 4'd7;

    // configuration
    logic [9:0] win_reg;
    logic       cont_reg;
    logic [7:0] lkey_reg, rkey_reg;

    // latched event
    logic        cmd_reg, mods_reg;
    logic [7:0]  code_reg;
    logic [31:0] now_reg;

    // block state
    logic [7:0]     pend_reg [PENDING_DEPTH];
    logic [7:0]     pt_reg   [PASSTHROUGH_DEPTH];
    logic [PCW-1:0] pc_reg;
    logic [TCW-1:0] ptc_reg;
    logic [31:0]    lct_reg;
    logic [3:0]     kc_reg;
    logic           lh_reg, rh_reg, lu_reg, ru_reg;

    // sequencer
    logic [3:0]     state_reg;
    logic [PCW-1:0] idx_reg, rtot_reg;
    logic [TCW-1:0] j_reg;
    logic           rl_reg, rr_reg, phase_reg;
    logic [1:0]     slot_reg, post_reg;
    logic [23:0]    str_reg;
    logic [4:0]     rcnt_reg;

    // output staging
    tscr_pkg::key_word_t cand_reg, out_reg;
    logic                cand_v_reg, m_valid_reg, last_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = last_reg;
    assign m_tdata   = {6'd0, out_reg.pressed, out_reg.shifted, out_reg.code};

    logic slot_free;
    assign slot_free = !m_valid_reg || m_tready;

    // decode of one event
    tscr_pkg::kana_row_t crow;
    logic effl, effr, is_l, is_r, is_rom, late, pass_cond;
    logic [31:0] d;
    logic [9:0]  win;
    logic [PCW-1:0] n_pc, pc1;
    logic [3:0]  n_kc, c0, kc1;
    logic        n_lh, n_rh, n_lu, n_ru, lh1, rh1, lu1, ru1, effl1, effr1, effl2, effr2;
    logic        do_res, res_l, res_r, wr_pend, push_pt;
    logic [1:0]  n_post;

    always_comb begin
        effl   = lh_reg && (cont_reg || !lu_reg);
        effr   = rh_reg && (cont_reg || !ru_reg);
        is_l   = (code_reg == lkey_reg);
        is_r   = !is_l && (code_reg == rkey_reg);
        crow   = tscr_pkg::kana_row(code_reg);
        is_rom = crow.hit;
        d      = now_reg - lct_reg;
        win    = (win_reg < tscr_pkg::WINDOW_MIN) ? tscr_pkg::WINDOW_MIN :
                 (win_reg > tscr_pkg::WINDOW_MAX) ? tscr_pkg::WINDOW_MAX : win_reg;
        late   = (pc_reg != '0) && !d[31] && (d > {22'd0, win});
        pass_cond = mods_reg || (!is_l && !is_r && !is_rom);
        n_pc = pc_reg; n_kc = kc_reg;
        n_lh = lh_reg; n_rh = rh_reg; n_lu = lu_reg; n_ru = ru_reg;
        do_res = 1'b0; res_l = effl; res_r = effr;
        wr_pend = 1'b0; push_pt = 1'b0; n_post = tscr_pkg::POST_NONE;
        pc1 = pc_reg; c0 = kc_reg; kc1 = kc_reg;
        lh1 = lh_reg; rh1 = rh_reg; lu1 = lu_reg; ru1 = ru_reg;
        effl1 = effl; effr1 = effr; effl2 = effl; effr2 = effr;
        if (!cmd_reg) begin
            if (pass_cond) begin
                do_res = 1'b1;
                n_pc   = '0;
                n_kc   = {3'd0, effl} + {3'd0, effr};
                push_pt = (ptc_reg < TCW'(PASSTHROUGH_DEPTH));
                n_post = tscr_pkg::POST_PRESS;
            end else if (is_l || is_r) begin
                c0  = late ? ({3'd0, effl} + {3'd0, effr}) : kc_reg;
                if (is_l) begin
                    lh1 = 1'b1; lu1 = 1'b0;
                end else begin
                    rh1 = 1'b1; ru1 = 1'b0;
                end
                effl1 = lh1 && (cont_reg || !lu1);
                effr1 = rh1 && (cont_reg || !ru1);
                kc1   = tscr_pkg::sat4({1'b0, c0} + 5'd1);
                do_res = late || (kc1 > 4'd1);
                res_l = late ? effl : effl1;
                res_r = late ? effr : effr1;
                n_lh = lh1; n_rh = rh1; n_lu = lu1; n_ru = ru1;
                if (kc1 > 4'd1) begin
                    if (is_l) n_lu = 1'b1;
                    else n_ru = 1'b1;
                    effl2 = n_lh && (cont_reg || !n_lu);
                    effr2 = n_rh && (cont_reg || !n_ru);
                    n_kc = {3'd0, effl2} + {3'd0, effr2};
                    n_pc = '0;
                end else begin
                    n_kc = kc1;
                    n_pc = late ? '0 : pc_reg;
                end
            end else begin
                wr_pend = (pc_reg < PCW'(PENDING_DEPTH));
                pc1 = wr_pend ? pc_reg + PCW'(1) : pc_reg;
                kc1 = tscr_pkg::sat4({1'b0, kc_reg} + 5'd1);
                if (kc1 > 4'd1) begin
                    do_res = 1'b1;
                    n_lu = lh_reg ? 1'b1 : lu_reg;
                    n_ru = rh_reg ? 1'b1 : ru_reg;
                    effl2 = lh_reg && (cont_reg || !n_lu);
                    effr2 = rh_reg && (cont_reg || !n_ru);
                    n_kc = {3'd0, effl2} + {3'd0, effr2};
                    n_pc = '0;
                end else begin
                    n_kc = kc1;
                    n_pc = pc1;
                end
            end
        end else begin
            if (is_l) begin
                n_lh = 1'b0; n_lu = 1'b0;
                if (!lu_reg && pc_reg == '0) n_post = tscr_pkg::POST_TAP;
                else if (pc_reg != '0) begin
                    do_res = 1'b1; res_l = 1'b0; res_r = effr; n_pc = '0;
                end
                n_kc = {3'd0, effr};
            end else if (is_r) begin
                n_rh = 1'b0; n_ru = 1'b0;
                if (!ru_reg && pc_reg == '0) n_post = tscr_pkg::POST_TAP;
                else if (pc_reg != '0) begin
                    do_res = 1'b1; res_l = effl; res_r = 1'b0; n_pc = '0;
                end
                n_kc = {3'd0, effl};
            end else if (is_rom && pc_reg != '0) begin
                do_res = 1'b1; n_pc = '0;
                n_kc = {3'd0, effl} + {3'd0, effr};
            end
        end
    end

    // word the current state wants to send
    tscr_pkg::kana_row_t row;
    logic [7:0] ch;
    logic [8:0] chk;
    logic       emit_req;
    tscr_pkg::key_word_t emit_word;

    always_comb begin
        row = tscr_pkg::kana_row(pend_reg[idx_reg[PIW-1:0]]);
        case (slot_reg)
            2'd2: ch = str_reg[23:16];
            2'd1: ch = str_reg[15:8];
            default: ch = str_reg[7:0];
        endcase
        chk = tscr_pkg::char_key(ch);
        emit_req = 1'b0;
        emit_word = '{pressed: 1'b0, shifted: 1'b0, code: code_reg};
        case (state_reg)
            ST_CHAR: begin
                emit_req = (ch != 8'd0);
                emit_word = '{pressed: !phase_reg, shifted: chk[8], code: chk[7:0]};
            end
            ST_POST: begin
                emit_req = (post_reg != tscr_pkg::POST_NONE);
                emit_word.pressed = (post_reg != tscr_pkg::POST_RELEASE);
            end
            default: emit_req = 1'b0;
        endcase
    end

    logic emit_go;
    assign emit_go = emit_req && slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= tscr_pkg::WINDOW_RESET; cont_reg <= 1'b0;
            lkey_reg <= tscr_pkg::LEFT_RESET; rkey_reg <= tscr_pkg::RIGHT_RESET;
            pc_reg <= '0; ptc_reg <= '0; lct_reg <= '0; kc_reg <= '0;
            lh_reg <= 1'b0; rh_reg <= 1'b0; lu_reg <= 1'b0; ru_reg <= 1'b0;
            state_reg <= ST_IDLE; cand_v_reg <= 1'b0; m_valid_reg <= 1'b0;
            last_reg <= 1'b0; rcnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tscr_pkg::CFG_WINDOW:     win_reg  <= cfg_data;
                    tscr_pkg::CFG_CONTINUOUS: cont_reg <= cfg_data[0];
                    tscr_pkg::CFG_LEFT_KEY:   lkey_reg <= cfg_data[7:0];
                    tscr_pkg::CFG_RIGHT_KEY:  rkey_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (emit_go && rcnt_reg < tscr_pkg::MAX_RESULTS) begin
                rcnt_reg <= rcnt_reg + 5'd1;
                cand_reg <= emit_word;
                cand_v_reg <= 1'b1;
                if (cand_v_reg) begin
                    out_reg <= cand_reg; last_reg <= 1'b0; m_valid_reg <= 1'b1;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg  <= s_tuser;
                        code_reg <= s_tdata[7:0];
                        now_reg  <= s_tdata[39:8];
                        mods_reg <= s_tdata[40];
                        rcnt_reg <= '0;
                        j_reg    <= '0;
                        state_reg <= s_tuser ? ST_SEARCH : ST_DECODE;
                    end
                end
                ST_SEARCH: begin
                    if (j_reg < ptc_reg) begin
                        j_reg <= j_reg + TCW'(1);
                        if (pt_reg[j_reg[TIW-1:0]] == code_reg) state_reg <= ST_SHIFT;
                    end else begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_SHIFT: begin
                    if (j_reg < ptc_reg) begin
                        pt_reg[TIW'(j_reg - TCW'(1))] <= pt_reg[j_reg[TIW-1:0]];
                        j_reg <= j_reg + TCW'(1);
                    end else begin
                        ptc_reg  <= ptc_reg - TCW'(1);
                        post_reg <= tscr_pkg::POST_RELEASE;
                        state_reg <= ST_POST;
                    end
                end
                ST_DECODE: begin
                    pc_reg <= n_pc; kc_reg <= n_kc;
                    lh_reg <= n_lh; rh_reg <= n_rh; lu_reg <= n_lu; ru_reg <= n_ru;
                    if (wr_pend) pend_reg[pc_reg[PIW-1:0]] <= code_reg;
                    if (!cmd_reg && !pass_cond && !is_l && !is_r) lct_reg <= now_reg;
                    if (push_pt) begin
                        pt_reg[ptc_reg[TIW-1:0]] <= code_reg;
                        ptc_reg <= ptc_reg + TCW'(1);
                    end
                    rtot_reg <= do_res ? pc1 : '0;
                    idx_reg  <= '0;
                    rl_reg <= res_l; rr_reg <= res_r;
                    post_reg <= n_post;
                    state_reg <= ST_LOOK;
                end
                ST_LOOK: begin
                    if (idx_reg < rtot_reg) begin
                        str_reg <= rl_reg ? row.lpl : (rr_reg ? row.rpl : row.plain);
                        slot_reg <= 2'd2;
                        phase_reg <= 1'b0;
                        state_reg <= ST_CHAR;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_CHAR: begin
                    if (!emit_req || (emit_go && phase_reg)) begin
                        phase_reg <= 1'b0;
                        if (slot_reg == 2'd0) begin
                            idx_reg <= idx_reg + PCW'(1);
                            state_reg <= ST_LOOK;
                        end else begin
                            slot_reg <= slot_reg - 2'd1;
                        end
                    end else if (emit_go) begin
                        phase_reg <= 1'b1;
                    end
                end
                ST_POST: begin
                    if (!emit_req) state_reg <= ST_FLUSH;
                    else if (emit_go) begin
                        if (post_reg == tscr_pkg::POST_TAP) post_reg <= tscr_pkg::POST_RELEASE;
                        else state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (slot_free) begin
                        if (cand_v_reg) begin
                            out_reg <= cand_reg; last_reg <= 1'b1; m_valid_reg <= 1'b1;
                        end
                        cand_v_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/tscr_checker.sv =====
// port-level checks of the thumb-shift chord resolver, bound to the top level
// depends on thumb_shift_chord_resolver ports only
module tscr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

endmodule

bind thumb_shift_chord_resolver tscr_checker u_tscr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/testbench.sv =====
// self-checking testbench for the thumb-shift chord resolver
// depends on tscr_pkg and thumb_shift_chord_resolver
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic       release_evt;
        logic [7:0] key;
        logic [31:0] stamp;
        logic       mods;
    } key_event_t;

    typedef struct {
        logic [7:0] code;
        logic       shifted;
        logic       pressed;
        logic       last;
    } emit_word_t;

    localparam int PEND_DEPTH = 8;
    localparam int PASS_DEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;

    thumb_shift_chord_resolver u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [9:0]  win_reg;
    logic        cont_reg;
    logic [7:0]  lkey_reg;
    logic [7:0]  rkey_reg;
    logic [7:0]  pend_keys [PEND_DEPTH];
    int          pend_cnt;
    logic [31:0] last_char_ms;
    int          chord_cnt;
    logic        l_held, r_held, l_used, r_used;
    logic [7:0]  pass_keys [PASS_DEPTH];
    int          pass_cnt;
    emit_word_t  step_words [$];

    key_event_t  pending_events [$];
    emit_word_t  expected_words [$];
    int          errors;
    int          cycles;
    logic        hold_sender;
    int          burst_left;
    int          gap_left;
    int          stall_phase;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic tscr_pkg::kana_row_t romaji_of(input logic [7:0] code);
        tscr_pkg::kana_row_t r;
        r = '{1'b1, 24'd0, 24'd0, 24'd0};
        case (code)
            8'd20: r = '{1'b1, 24'("."),  24'("la"),  24'd0};
            8'd26: r = '{1'b1, 24'("ka"), 24'("e"),   24'("ga")};
            8'd8:  r = '{1'b1, 24'("ta"), 24'("ri"),  24'("da")};
            8'd21: r = '{1'b1, 24'("ko"), 24'("lya"), 24'("go")};
            8'd23: r = '{1'b1, 24'("sa"), 24'("re"),  24'("za")};
            8'd28: r = '{1'b1, 24'("ra"), 24'("pa"),  24'("yo")};
            8'd24: r = '{1'b1, 24'("ti"), 24'("di"),  24'("ni")};
            8'd12: r = '{1'b1, 24'("ku"), 24'("gu"),  24'("ru")};
            8'd18: r = '{1'b1, 24'("tu"), 24'("du"),  24'("ma")};
            8'd19: r = '{1'b1, 24'(","),  24'("pi"),  24'("le")};
            8'd4:  r = '{1'b1, 24'("u"),  24'("wo"),  24'("vu")};
            8'd22: r = '{1'b1, 24'("si"), 24'("a"),   24'("zi")};
            8'd7:  r = '{1'b1, 24'("te"), 24'("na"),  24'("de")};
            8'd9:  r = '{1'b1, 24'("ke"), 24'("lyu"), 24'("ge")};
            8'd10: r = '{1'b1, 24'("se"), 24'("mo"),  24'("ze")};
            8'd11: r = '{1'b1, 24'("ha"), 24'("ba"),  24'("mi")};
            8'd13: r = '{1'b1, 24'("to"), 24'("do"),  24'("o")};
            8'd14: r = '{1'b1, 24'("ki"), 24'("gi"),  24'("no")};
            8'd15: r = '{1'b1, 24'("i"),  24'("po"),  24'("lyo")};
            8'd51: r = '{1'b1, 24'("nn"), 24'd0,      24'("ltu")};
            8'd29: r = '{1'b1, 24'("."),  24'("lu"),  24'd0};
            8'd27: r = '{1'b1, 24'("hi"), 24'("-"),   24'("bi")};
            8'd6:  r = '{1'b1, 24'("su"), 24'("ro"),  24'("zu")};
            8'd25: r = '{1'b1, 24'("hu"), 24'("ya"),  24'("bu")};
            8'd5:  r = '{1'b1, 24'("he"), 24'("li"),  24'("be")};
            8'd17: r = '{1'b1, 24'("me"), 24'("pu"),  24'("nu")};
            8'd16: r = '{1'b1, 24'("so"), 24'("zo"),  24'("yu")};
            8'd54: r = '{1'b1, 24'("ne"), 24'("pe"),  24'("mu")};
            8'd55: r = '{1'b1, 24'("ho"), 24'("bo"),  24'("wa")};
            8'd56: r = '{1'b1, 24'("/"),  24'("?"),   24'("lo")};
            8'd47: r = '{1'b1, 24'(","),  24'd0,      24'd0};
            default: r = '{1'b0, 24'd0, 24'd0, 24'd0};
        endcase
        return r;
    endfunction

    function automatic void push_word(input logic [7:0] code, input logic sh, input logic pr);
        emit_word_t w;
        if (step_words.size() >= 16) return;
        w.code = code;
        w.shifted = sh;
        w.pressed = pr;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void tap_key(input logic [7:0] code, input logic sh);
        push_word(code, sh, 1'b1);
        push_word(code, sh, 1'b0);
    endfunction

    function automatic void type_romaji(input logic [23:0] s);
        logic [7:0] c;
        for (int i = 2; i >= 0; i--) begin
            c = s[i*8 +: 8];
            if (c == "-") tap_key(tscr_pkg::CODE_MINUS, 1'b0);
            else if (c == ",") tap_key(tscr_pkg::CODE_COMMA, 1'b0);
            else if (c == ".") tap_key(tscr_pkg::CODE_DOT, 1'b0);
            else if (c == "/") tap_key(tscr_pkg::CODE_SLASH, 1'b0);
            else if (c == "?") tap_key(tscr_pkg::CODE_SLASH, 1'b1);
            else if (c >= "a" && c <= "z") tap_key(tscr_pkg::CODE_A + (c - 8'h61), 1'b0);
        end
    endfunction

    function automatic logic left_active();
        return l_held && (cont_reg || !l_used);
    endfunction

    function automatic logic right_active();
        return r_held && (cont_reg || !r_used);
    endfunction

    function automatic void set_chord_cnt(input int v);
        chord_cnt = v > 15 ? 15 : v;
    endfunction

    function automatic void recount_chord();
        set_chord_cnt(int'(left_active()) + int'(right_active()) + pend_cnt);
    endfunction

    function automatic void flush_pending();
        logic lsh, rsh;
        tscr_pkg::kana_row_t row;
        lsh = left_active();
        rsh = right_active();
        for (int i = 0; i < pend_cnt; i++) begin
            row = romaji_of(pend_keys[i]);
            if (row.hit) type_romaji(lsh ? row.lpl : (rsh ? row.rpl : row.plain));
        end
        pend_cnt = 0;
        set_chord_cnt(int'(left_active()) + int'(right_active()));
    endfunction

    function automatic void forward_press(input logic [7:0] code);
        flush_pending();
        if (pass_cnt < PASS_DEPTH) begin
            pass_keys[pass_cnt] = code;
            pass_cnt++;
        end
        push_word(code, 1'b0, 1'b1);
    endfunction

    function automatic void thumb_down(input logic [31:0] now, input logic is_left);
        logic [31:0] d;
        int unsigned w;
        if (pend_cnt > 0) begin
            d = now - last_char_ms;
            w = win_reg;
            if (w < 1) w = 1;
            if (w > 1000) w = 1000;
            if (!d[31] && d > w) flush_pending();
        end
        if (is_left) begin l_held = 1'b1; l_used = 1'b0; end
        else begin r_held = 1'b1; r_used = 1'b0; end
        set_chord_cnt(chord_cnt + 1);
        if (chord_cnt > 1) begin
            flush_pending();
            if (is_left) l_used = 1'b1; else r_used = 1'b1;
            recount_chord();
        end
    endfunction

    function automatic void thumb_up(input logic [7:0] code, input logic is_left);
        logic solo;
        solo = !(is_left ? l_used : r_used) && pend_cnt == 0;
        if (is_left) begin l_held = 1'b0; l_used = 1'b0; end
        else begin r_held = 1'b0; r_used = 1'b0; end
        if (solo) tap_key(code, 1'b0);
        else if (pend_cnt > 0) flush_pending();
        set_chord_cnt(int'(is_left ? right_active() : left_active()) + pend_cnt);
    endfunction

    function automatic void predict_event(input key_event_t ev);
        logic found;
        tscr_pkg::kana_row_t row;
        step_words.delete();
        row = romaji_of(ev.key);
        if (!ev.release_evt) begin
            if (ev.mods) forward_press(ev.key);
            else if (ev.key == lkey_reg) thumb_down(ev.stamp, 1'b1);
            else if (ev.key == rkey_reg) thumb_down(ev.stamp, 1'b0);
            else if (row.hit) begin
                if (pend_cnt < PEND_DEPTH) begin
                    pend_keys[pend_cnt] = ev.key;
                    pend_cnt++;
                end
                last_char_ms = ev.stamp;
                set_chord_cnt(chord_cnt + 1);
                if (chord_cnt > 1) begin
                    flush_pending();
                    if (l_held) l_used = 1'b1;
                    if (r_held) r_used = 1'b1;
                    recount_chord();
                end
            end else forward_press(ev.key);
        end else begin
            found = 1'b0;
            for (int i = 0; i < pass_cnt && !found; i++) begin
                if (pass_keys[i] == ev.key) begin
                    for (int j = i; j + 1 < pass_cnt; j++) pass_keys[j] = pass_keys[j + 1];
                    pass_cnt--;
                    push_word(ev.key, 1'b0, 1'b0);
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (ev.key == lkey_reg) thumb_up(lkey_reg, 1'b1);
                else if (ev.key == rkey_reg) thumb_up(rkey_reg, 1'b0);
                else if (row.hit && pend_cnt > 0) flush_pending();
            end
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function automatic logic [7:0] rom_key();
        logic [7:0] codes [31] = '{20, 26, 8, 21, 23, 28, 24, 12, 18, 19, 4, 22, 7, 9, 10,
                                   11, 13, 14, 15, 51, 29, 27, 6, 25, 5, 17, 16, 54, 55,
                                   56, 47};
        return codes[$urandom_range(30)];
    endfunction

    function automatic void add_event(input logic rel, input logic [7:0] key,
                                      input logic [31:0] stamp, input logic mods);
        key_event_t ev;
        ev.release_evt = rel;
        ev.key = key;
        ev.stamp = stamp;
        ev.mods = mods;
        pending_events.push_back(ev);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_event(pending_events.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (hold_sender || pending_events.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_events[0].release_evt;
                s_tdata <= {7'd0, pending_events[0].mods, pending_events[0].stamp,
                            pending_events[0].key};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(8, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        emit_word_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            cycles <= cycles + 1;
            stall_phase <= (stall_phase + 1) % 23;
            m_tready <= (stall_phase < 8) ? 1'b1 : ($urandom_range(3) != 0);
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: code %0d", m_tdata[7:0]);
                    errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (m_tdata[7:0] !== w.code) begin
                        $error("out_code: expected %0d, actual %0d", w.code, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[8] !== w.shifted) begin
                        $error("out_shifted: expected %0d, actual %0d", w.shifted, m_tdata[8]);
                        errors++;
                    end
                    if (m_tdata[9] !== w.pressed) begin
                        $error("out_pressed: expected %0d, actual %0d", w.pressed, m_tdata[9]);
                        errors++;
                    end
                    if (m_tlast !== w.last) begin
                        $error("last: expected %0d, actual %0d", w.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("thumb_shift_chord_resolver regression: fail");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_events.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            tscr_pkg::CFG_WINDOW:     win_reg = val;
            tscr_pkg::CFG_CONTINUOUS: cont_reg = val[0];
            tscr_pkg::CFG_LEFT_KEY:   lkey_reg = val[7:0];
            default:                  rkey_reg = val[7:0];
        endcase
    endtask

    task automatic random_phase(input int n);
        logic [31:0] t;
        logic [7:0] k;
        t = $urandom;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    // character then thumb inside or outside the window
                    k = rom_key();
                    t = t + $urandom_range(300);
                    add_event(1'b0, k, t, 1'b0);
                    t = t + $urandom_range(300);
                    add_event(1'b0, $urandom_range(1) ? lkey_reg : rkey_reg, t, 1'b0);
                    add_event(1'b1, k, t + 5, 1'b0);
                    add_event(1'b1, $urandom_range(1) ? lkey_reg : rkey_reg, t + 9, 1'b0);
                    i = i + 3;
                end
                3, 4: begin
                    k = rom_key();
                    t = t + $urandom_range(200);
                    add_event(1'b0, k, t, 1'b0);
                    add_event(1'b1, k, t + 40, 1'b0);
                    i++;
                end
                5: begin
                    k = 8'($urandom);
                    add_event(1'b0, k, t, 1'($urandom_range(1)));
                    add_event(1'b1, k, t + 20, 1'($urandom_range(1)));
                    i++;
                end
                6: add_event(1'b0, rom_key(), $urandom, 1'b0);
                default: add_event(1'($urandom_range(1)), 8'($urandom), $urandom,
                                   1'($urandom_range(1)));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tscr_pkg::CFG_WINDOW;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        hold_sender = 1'b0;
        win_reg = tscr_pkg::WINDOW_RESET;
        cont_reg = 1'b0;
        lkey_reg = tscr_pkg::LEFT_RESET;
        rkey_reg = tscr_pkg::RIGHT_RESET;
        pend_cnt = 0;
        last_char_ms = '0;
        chord_cnt = 0;
        l_held = 1'b0; r_held = 1'b0; l_used = 1'b0; r_used = 1'b0;
        pass_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: solo taps, chords, timeout, wraparound, a full pass-through store, field extremes
        add_event(1'b0, 8'd44, 32'd0, 1'b0);
        add_event(1'b1, 8'd44, 32'd10, 1'b0);
        add_event(1'b0, 8'd26, 32'd100, 1'b0);
        add_event(1'b0, 8'd44, 32'd150, 1'b0);
        add_event(1'b1, 8'd44, 32'd160, 1'b0);
        add_event(1'b0, 8'd56, 32'hFFFF_FFF0, 1'b0);
        add_event(1'b0, 8'd44, 32'd5, 1'b0);
        add_event(1'b1, 8'd44, 32'd10, 1'b0);
        add_event(1'b0, 8'd21, 32'd1000, 1'b0);
        add_event(1'b0, 8'd138, 32'd2000, 1'b0);
        add_event(1'b1, 8'd138, 32'd2010, 1'b0);
        add_event(1'b0, 8'd20, 32'h8000_0000, 1'b0);
        add_event(1'b0, 8'd138, 32'd0, 1'b0);
        add_event(1'b1, 8'd138, 32'd1, 1'b0);
        for (int i = 0; i < 9; i++) add_event(1'b0, 8'(200 + i), 32'hFFFF_FFFF, 1'b1);
        add_event(1'b1, 8'd208, 32'd0, 1'b0);
        add_event(1'b1, 8'd200, 32'd0, 1'b0);
        add_event(1'b0, 8'd255, 32'd7, 1'b0);
        add_event(1'b1, 8'd0, 32'd7, 1'b1);
        wait_idle();

        // pending characters typed while both thumbs are held in continuous mode
        write_reg(tscr_pkg::CFG_CONTINUOUS, 10'd1);
        write_reg(tscr_pkg::CFG_WINDOW, 10'd1000);
        add_event(1'b0, 8'd44, 32'd0, 1'b0);
        add_event(1'b0, 8'd138, 32'd1, 1'b0);
        for (int i = 0; i < 4; i++) add_event(1'b0, rom_key(), 32'd2 + i, 1'b0);
        add_event(1'b1, 8'd138, 32'd9, 1'b0);
        add_event(1'b1, 8'd44, 32'd9, 1'b0);
        random_phase(15);
        wait_idle();

        write_reg(tscr_pkg::CFG_WINDOW, 10'd0);
        write_reg(tscr_pkg::CFG_CONTINUOUS, 10'd0);
        write_reg(tscr_pkg::CFG_LEFT_KEY, 10'd26);
        write_reg(tscr_pkg::CFG_RIGHT_KEY, 10'd26);
        random_phase(15);
        wait_idle();

        write_reg(tscr_pkg::CFG_WINDOW, 10'd1023);
        write_reg(tscr_pkg::CFG_LEFT_KEY, 10'd255);
        write_reg(tscr_pkg::CFG_RIGHT_KEY, 10'd0);
        random_phase(15);

        // sender holds off with events still queued until the block has drained
        while (pending_events.size() > 10) @(posedge aclk);
        hold_sender <= 1'b1;
        @(posedge aclk);
        while (s_tvalid || expected_words.size() > 0) @(posedge aclk);
        hold_sender <= 1'b0;
        wait_idle();

        write_reg(tscr_pkg::CFG_WINDOW, 10'd130);
        write_reg(tscr_pkg::CFG_LEFT_KEY, 10'd44);
        write_reg(tscr_pkg::CFG_RIGHT_KEY, 10'd138);
        write_reg(tscr_pkg::CFG_CONTINUOUS, 10'd1);
        random_phase(20);
        wait_idle();

        if (errors == 0) begin
            $display("thumb_shift_chord_resolver regression: pass");
        end else begin
            $display("thumb_shift_chord_resolver regression: fail");
        end
        $finish;
    end
endmodule
